// ===== src/cth_pkg.sv =====
package cth_pkg;

    localparam int ADDR_W = 19;
    localparam int CNT_W  = 32;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              access_kind;
        logic              is_write;
    } t_req;

    typedef struct packed {
        logic             lru_hit;
        logic             plru_hit;
        logic             lru_victim_dirty;
        logic             plru_victim_dirty;
        logic [CNT_W-1:0] inst_accesses;
        logic [CNT_W-1:0] data_accesses;
        logic [CNT_W-1:0] lru_inst_hits;
        logic [CNT_W-1:0] lru_data_hits;
        logic [CNT_W-1:0] plru_inst_hits;
        logic [CNT_W-1:0] plru_data_hits;
    } t_res;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LOOK
    } t_state;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage

// ===== src/cth_chan_if.sv =====
interface cth_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/cache_tag_replacement_lru_plru_core.sv =====
// Channel  Dir  Word   Accepted when
// i_req    in   t_req  i_req.valid & i_req.ready
// o_res    out  t_res  o_res.valid & o_res.ready
//
// Each access goes through accept (set quotient), set-row read from the
// row memory, then lookup and write-back of the whole set row.
// After reset a clearing pass writes every set row with i_req.ready low.
// A result waits in the output register; the next access is taken meanwhile
// and holds in lookup only if that register is still full.
module cache_tag_replacement_lru_plru_core
    import cth_pkg::*;
#(
    parameter int NUM_WAYS    = 4,
    parameter int NUM_SETS    = 16,
    parameter int OFFSET_BITS = 5,
    parameter int TAG_BITS    = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cth_chan_if.sink    i_req,
    cth_chan_if.source  o_res
);
    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int LINE_W = ADDR_W - OFFSET_BITS;
    localparam int DIV_SH = LINE_W + $clog2(NUM_SETS);
    localparam int unsigned RECIP = ((32'd1 << DIV_SH) + NUM_SETS - 1) / NUM_SETS;
    localparam int RCP_W  = LINE_W + 1;
    localparam int PROD_W = LINE_W + RCP_W;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
        logic [WAY_W-1:0]    rank;
    } t_lru_line;

    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
        logic                mru;
    } t_plru_line;

    typedef struct packed {
        t_lru_line  [NUM_WAYS-1:0] lru;
        t_plru_line [NUM_WAYS-1:0] plru;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    t_state r_state, n_state;
    logic [SET_W-1:0]  r_clr;
    logic [LINE_W-1:0] r_line, r_quot;
    logic              r_kind, r_wr;
    logic [SET_W-1:0]  r_set;
    logic              r_out_valid;
    t_res              r_out;
    logic [CNT_W-1:0]  r_inst, r_data, r_lru_ih, r_lru_dh, r_plru_ih, r_plru_dh;
    logic [CNT_W-1:0]  n_inst, n_data, n_lru_ih, n_lru_dh, n_plru_ih, n_plru_dh;

    logic              accept, commit;
    logic [LINE_W-1:0] w_line, w_quot, w_set_full;
    logic [PROD_W-1:0] w_prod;
    logic [SET_W-1:0]  w_set;
    logic [TAG_BITS-1:0] w_tag;

    logic              ram_we, ram_re;
    logic [SET_W-1:0]  ram_waddr;
    logic [ROW_W-1:0]  ram_wdata, ram_rdata;
    t_row              rd_row, new_row, clr_row;

    logic              l_hit, l_inv, p_hit, p_inv;
    logic [WAY_W-1:0]  l_hway, l_iway, l_oway, l_way, l_rank;
    logic [WAY_W-1:0]  p_hway, p_iway, p_cway, p_way;
    logic              l_vd, p_vd;
    logic [NUM_WAYS-1:0] p_mset;

    // Set and tag by reciprocal multiply: exact for every line number.
    assign w_line = i_req.data.address[ADDR_W-1:OFFSET_BITS];
    assign w_prod = PROD_W'(w_line) * PROD_W'(RCP_W'(RECIP));
    assign w_quot = LINE_W'(w_prod >> DIV_SH);
    assign w_set_full = r_line - LINE_W'(r_quot * LINE_W'(NUM_SETS));
    assign w_set = SET_W'(w_set_full);
    assign w_tag = TAG_BITS'(r_quot);

    assign accept = i_req.valid && i_req.ready;
    assign commit = (r_state == S_LOOK) && (!r_out_valid || o_res.ready);

    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == SET_W'(NUM_SETS - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_LOOK;
            end
            S_LOOK: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            clr_row.lru[w]  = '{valid: 1'b0, dirty: 1'b0, tag: '0, rank: WAY_W'(w)};
            clr_row.plru[w] = '{valid: 1'b0, dirty: 1'b0, tag: '0, mru: 1'b0};
        end
    end

    assign rd_row = t_row'(ram_rdata);

    // Lookup, victim choice and recency update of one set row.
    always_comb begin
        l_hit = 1'b0; l_inv = 1'b0; l_hway = '0; l_iway = '0; l_oway = '0;
        p_hit = 1'b0; p_inv = 1'b0; p_hway = '0; p_iway = '0; p_cway = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rd_row.lru[w].valid && rd_row.lru[w].tag == w_tag) begin
                l_hit  = 1'b1;
                l_hway = WAY_W'(w);
            end
            if (!rd_row.lru[w].valid) begin
                l_inv  = 1'b1;
                l_iway = WAY_W'(w);
            end
            if (rd_row.lru[w].rank == WAY_W'(NUM_WAYS - 1)) l_oway = WAY_W'(w);
            if (rd_row.plru[w].valid && rd_row.plru[w].tag == w_tag) begin
                p_hit  = 1'b1;
                p_hway = WAY_W'(w);
            end
            if (!rd_row.plru[w].valid) begin
                p_inv  = 1'b1;
                p_iway = WAY_W'(w);
            end
            if (!rd_row.plru[w].mru) p_cway = WAY_W'(w);
        end

        l_way  = l_hit ? l_hway : (l_inv ? l_iway : l_oway);
        p_way  = p_hit ? p_hway : (p_inv ? p_iway : p_cway);
        l_vd   = !l_hit && rd_row.lru[l_way].valid && rd_row.lru[l_way].dirty;
        p_vd   = !p_hit && rd_row.plru[p_way].valid && rd_row.plru[p_way].dirty;
        l_rank = rd_row.lru[l_way].rank;

        new_row = rd_row;
        if (l_hit) begin
            new_row.lru[l_way].dirty = rd_row.lru[l_way].dirty | r_wr;
        end else begin
            new_row.lru[l_way].valid = 1'b1;
            new_row.lru[l_way].dirty = r_wr;
            new_row.lru[l_way].tag   = w_tag;
        end
        if (p_hit) begin
            new_row.plru[p_way].dirty = rd_row.plru[p_way].dirty | r_wr;
        end else begin
            new_row.plru[p_way].valid = 1'b1;
            new_row.plru[p_way].dirty = r_wr;
            new_row.plru[p_way].tag   = w_tag;
        end

        for (int w = 0; w < NUM_WAYS; w++) begin
            if (rd_row.lru[w].rank < l_rank) new_row.lru[w].rank = rd_row.lru[w].rank + 1'b1;
            p_mset[w] = rd_row.plru[w].mru || (WAY_W'(w) == p_way);
        end
        new_row.lru[l_way].rank = '0;

        // All MRU bits set: keep only the touched one.
        for (int w = 0; w < NUM_WAYS; w++) begin
            new_row.plru[w].mru = (&p_mset) ? (WAY_W'(w) == p_way) : p_mset[w];
        end
    end

    always_comb begin
        n_inst    = r_kind ? r_inst : sat_inc(r_inst);
        n_data    = r_kind ? sat_inc(r_data) : r_data;
        n_lru_ih  = (l_hit && !r_kind) ? sat_inc(r_lru_ih) : r_lru_ih;
        n_lru_dh  = (l_hit && r_kind) ? sat_inc(r_lru_dh) : r_lru_dh;
        n_plru_ih = (p_hit && !r_kind) ? sat_inc(r_plru_ih) : r_plru_ih;
        n_plru_dh = (p_hit && r_kind) ? sat_inc(r_plru_dh) : r_plru_dh;
    end

    assign ram_we    = (r_state == S_CLEAR) || commit;
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr : r_set;
    assign ram_wdata = (r_state == S_CLEAR) ? ROW_W'(clr_row) : ROW_W'(new_row);
    assign ram_re    = (r_state == S_READ);

    cth_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (w_set),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            r_inst      <= '0;
            r_data      <= '0;
            r_lru_ih    <= '0;
            r_lru_dh    <= '0;
            r_plru_ih   <= '0;
            r_plru_dh   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (commit) begin
                r_out_valid <= 1'b1;
                r_inst      <= n_inst;
                r_data      <= n_data;
                r_lru_ih    <= n_lru_ih;
                r_lru_dh    <= n_lru_dh;
                r_plru_ih   <= n_plru_ih;
                r_plru_dh   <= n_plru_dh;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line <= w_line;
            r_quot <= w_quot;
            r_kind <= i_req.data.access_kind;
            r_wr   <= i_req.data.is_write;
        end
        if (r_state == S_READ) r_set <= w_set;
        if (commit) begin
            r_out.lru_hit           <= l_hit;
            r_out.plru_hit          <= p_hit;
            r_out.lru_victim_dirty  <= l_vd;
            r_out.plru_victim_dirty <= p_vd;
            r_out.inst_accesses     <= n_inst;
            r_out.data_accesses     <= n_data;
            r_out.lru_inst_hits     <= n_lru_ih;
            r_out.lru_data_hits     <= n_lru_dh;
            r_out.plru_inst_hits    <= n_plru_ih;
            r_out.plru_data_hits    <= n_plru_dh;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

`ifndef NO_ASSERTIONS
    a_word_from_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_LOOK)
        else $error("result word appeared without a lookup");

    a_lookup_commits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK && !r_out_valid) |=> r_out_valid && r_state == S_IDLE)
        else $error("lookup with free output register did not commit");

    a_inst_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_inst >= $past(r_inst))
        else $error("instruction access count went down");

    a_hits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lru_ih <= r_inst && r_plru_ih <= r_inst && r_lru_dh <= r_data &&
        r_plru_dh <= r_data)
        else $error("hit count exceeds access count");
`endif

endmodule

// ===== src/cth_ram.sv =====
module cth_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// ===== tb/sv/cth_access_checker.sv =====
`timescale 1ns / 1ps

module cth_access_checker
    import cth_pkg::*;
#(
    parameter int NUM_WAYS    = 4,
    parameter int NUM_SETS    = 16,
    parameter int OFFSET_BITS = 5,
    parameter int TAG_BITS    = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_req_ready,
    input  t_req i_req_word,
    input  logic i_res_valid,
    input  logic i_res_ready,
    input  t_res i_res_word,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int RANK_BITS = $clog2(NUM_WAYS);

    // LRU directory
    logic [TAG_BITS-1:0]  lru_tag   [NUM_SETS][NUM_WAYS];
    logic                 lru_valid [NUM_SETS][NUM_WAYS];
    logic                 lru_dirty [NUM_SETS][NUM_WAYS];
    logic [RANK_BITS-1:0] lru_rank  [NUM_SETS][NUM_WAYS];
    // bit-PLRU directory
    logic [TAG_BITS-1:0]  plru_tag   [NUM_SETS][NUM_WAYS];
    logic                 plru_valid [NUM_SETS][NUM_WAYS];
    logic                 plru_dirty [NUM_SETS][NUM_WAYS];
    logic                 plru_mru   [NUM_SETS][NUM_WAYS];

    logic [CNT_W-1:0] inst_count;
    logic [CNT_W-1:0] data_count;
    logic [CNT_W-1:0] lru_hit_count  [2];
    logic [CNT_W-1:0] plru_hit_count [2];

    t_res expected_results [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_res predict_access(input t_req r);
        t_res                 res;
        int                   set;
        logic [TAG_BITS-1:0]  tag;
        int                   kind;
        logic                 wr;
        int                   way;
        logic [RANK_BITS-1:0] old_rank;
        logic                 all_mru;
        res  = '0;
        set  = (NUM_SETS > 1) ? int'(r.address[OFFSET_BITS +: SET_BITS]) : 0;
        tag  = r.address[OFFSET_BITS + SET_BITS +: TAG_BITS];
        kind = int'(r.access_kind);
        wr   = r.is_write;

        if (r.access_kind) begin
            if (data_count != '1) data_count++;
        end else begin
            if (inst_count != '1) inst_count++;
        end

        // LRU: hit, else first invalid way, else the oldest rank
        way = -1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way < 0 && lru_valid[set][w] && lru_tag[set][w] == tag) way = w;
        end
        if (way >= 0) begin
            res.lru_hit = 1'b1;
            lru_dirty[set][way] |= wr;
        end else begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (way < 0 && !lru_valid[set][w]) way = w;
            end
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (way < 0 && lru_rank[set][w] == RANK_BITS'(NUM_WAYS - 1)) way = w;
            end
            if (way < 0) way = 0;
            if (lru_valid[set][way]) res.lru_victim_dirty = lru_dirty[set][way];
            lru_tag[set][way]   = tag;
            lru_valid[set][way] = 1'b1;
            lru_dirty[set][way] = wr;
        end
        // age every way that was more recent than the touched one
        old_rank = lru_rank[set][way];
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (lru_rank[set][w] < old_rank) lru_rank[set][w]++;
        end
        lru_rank[set][way] = '0;

        // bit-PLRU: hit, else first invalid way, else first clear MRU bit
        way = -1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (way < 0 && plru_valid[set][w] && plru_tag[set][w] == tag) way = w;
        end
        if (way >= 0) begin
            res.plru_hit = 1'b1;
            plru_dirty[set][way] |= wr;
        end else begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (way < 0 && !plru_valid[set][w]) way = w;
            end
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (way < 0 && !plru_mru[set][w]) way = w;
            end
            if (way < 0) way = 0;
            if (plru_valid[set][way]) res.plru_victim_dirty = plru_dirty[set][way];
            plru_tag[set][way]   = tag;
            plru_valid[set][way] = 1'b1;
            plru_dirty[set][way] = wr;
        end
        plru_mru[set][way] = 1'b1;
        all_mru = 1'b1;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (!plru_mru[set][w]) all_mru = 1'b0;
        end
        // all set: keep only the touched way, lines stay valid
        if (all_mru) begin
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (w != way) plru_mru[set][w] = 1'b0;
            end
        end

        if (res.lru_hit && lru_hit_count[kind] != '1) lru_hit_count[kind]++;
        if (res.plru_hit && plru_hit_count[kind] != '1) plru_hit_count[kind]++;

        res.inst_accesses  = inst_count;
        res.data_accesses  = data_count;
        res.lru_inst_hits  = lru_hit_count[0];
        res.lru_data_hits  = lru_hit_count[1];
        res.plru_inst_hits = plru_hit_count[0];
        res.plru_data_hits = plru_hit_count[1];
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        t_res want;
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_SETS; s++) begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    lru_tag[s][w]    = '0;
                    lru_valid[s][w]  = 1'b0;
                    lru_dirty[s][w]  = 1'b0;
                    lru_rank[s][w]   = RANK_BITS'(w);
                    plru_tag[s][w]   = '0;
                    plru_valid[s][w] = 1'b0;
                    plru_dirty[s][w] = 1'b0;
                    plru_mru[s][w]   = 1'b0;
                end
            end
            inst_count        = '0;
            data_count        = '0;
            lru_hit_count[0]  = '0;
            lru_hit_count[1]  = '0;
            plru_hit_count[0] = '0;
            plru_hit_count[1] = '0;
            expected_results.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result word with nothing outstanding: %h",
                                 $time, i_res_word);
                end else begin
                    want = expected_results.pop_front();
                    check_field("lru_hit", want.lru_hit, i_res_word.lru_hit);
                    check_field("plru_hit", want.plru_hit, i_res_word.plru_hit);
                    check_field("lru_victim_dirty", want.lru_victim_dirty,
                                i_res_word.lru_victim_dirty);
                    check_field("plru_victim_dirty", want.plru_victim_dirty,
                                i_res_word.plru_victim_dirty);
                    check_field("inst_accesses", want.inst_accesses,
                                i_res_word.inst_accesses);
                    check_field("data_accesses", want.data_accesses,
                                i_res_word.data_accesses);
                    check_field("lru_inst_hits", want.lru_inst_hits,
                                i_res_word.lru_inst_hits);
                    check_field("lru_data_hits", want.lru_data_hits,
                                i_res_word.lru_data_hits);
                    check_field("plru_inst_hits", want.plru_inst_hits,
                                i_res_word.plru_inst_hits);
                    check_field("plru_data_hits", want.plru_data_hits,
                                i_res_word.plru_data_hits);
                end
            end
            if (i_req_valid && i_req_ready) begin
                want = predict_access(i_req_word);
                expected_results.insert(expected_results.size(), want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import cth_pkg::*;

    localparam int RANDOM_ACCESSES = 1700;
    localparam int QUIET_TAIL      = 200;
    localparam int LONG_HOLD       = 250;
    localparam int POOL_TAGS       = 6;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    // idling control shared by the sender and the receiver
    bit quiet;
    bit hold_request;

    logic [9:0] tag_pool [16][POOL_TAGS];

    cth_chan_if #(.T(t_req)) req_if ();
    cth_chan_if #(.T(t_res)) res_if ();

    cache_tag_replacement_lru_plru_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    cth_access_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_if.valid),
        .i_req_ready  (req_if.ready),
        .i_req_word   (req_if.data),
        .i_res_valid  (res_if.valid),
        .i_res_ready  (res_if.ready),
        .i_res_word   (res_if.data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic logic [18:0] line_addr(input logic [9:0] tag, input logic [3:0] set,
                                              input logic [4:0] off);
        return {tag, set, off};
    endfunction

    // Offer one access word and hold it until it is taken
    task automatic offer_access(input logic [18:0] addr, input logic kind, input logic wr,
                                input int gap);
        @(negedge i_clk);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= '{address: addr, access_kind: kind, is_write: wr};
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // receiver: random stalls, one long hold-off on request, none when quiet
    initial begin
        res_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    initial begin : stimulus
        int         gap_odds;
        int         gap;
        int         set;
        logic [9:0] tag;
        logic [18:0] addr;
        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        quiet        = 1'b0;
        hold_request = 1'b0;
        for (int s = 0; s < 16; s++)
            for (int k = 0; k < POOL_TAGS; k++)
                tag_pool[s][k] = 10'($urandom);
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes: tag zero in a clean set, all-ones address, both kinds
        offer_access(19'h00000, 1'b0, 1'b0, 0);
        offer_access(19'h00000, 1'b1, 1'b1, 0);
        offer_access(19'h7FFFF, 1'b1, 1'b1, 0);
        offer_access(19'h7FFE0, 1'b0, 1'b0, 1);
        // fill set 5 dirty, then refresh two ways by hits
        offer_access(line_addr(10'd1, 4'd5, 5'd0), 1'b0, 1'b1, 0);
        offer_access(line_addr(10'd2, 4'd5, 5'd7), 1'b1, 1'b1, 0);
        offer_access(line_addr(10'd3, 4'd5, 5'd31), 1'b0, 1'b1, 0);
        offer_access(line_addr(10'd4, 4'd5, 5'd16), 1'b1, 1'b1, 2);
        offer_access(line_addr(10'd1, 4'd5, 5'd3), 1'b0, 1'b0, 0);
        offer_access(line_addr(10'd2, 4'd5, 5'd9), 1'b1, 1'b0, 0);
        // dirty evictions; both policies evict the same way first, then differ
        offer_access(line_addr(10'd5, 4'd5, 5'd0), 1'b1, 1'b0, 0);
        offer_access(line_addr(10'd6, 4'd5, 5'd0), 1'b0, 1'b0, 0);
        offer_access(line_addr(10'd1, 4'd5, 5'd1), 1'b1, 1'b0, 0);
        offer_access(line_addr(10'd4, 4'd5, 5'd2), 1'b0, 1'b1, 0);
        // clean victims in set 9
        offer_access(line_addr(10'h155, 4'd9, 5'd0), 1'b0, 1'b0, 0);
        offer_access(line_addr(10'h2AA, 4'd9, 5'd0), 1'b0, 1'b0, 0);
        offer_access(line_addr(10'h3FF, 4'd9, 5'd0), 1'b1, 1'b0, 0);
        offer_access(line_addr(10'h000, 4'd9, 5'd0), 1'b1, 1'b0, 0);
        offer_access(line_addr(10'h0F0, 4'd9, 5'd21), 1'b0, 1'b0, 0);
        offer_access(line_addr(10'h155, 4'd9, 5'd10), 1'b1, 1'b1, 0);

        // random part: mostly reuse of a small tag pool per set
        hold_request = 1'b1;
        gap_odds     = 4;
        for (int n = 0; n < RANDOM_ACCESSES; n++) begin
            if (n == RANDOM_ACCESSES - QUIET_TAIL) quiet = 1'b1;
            if (n % 100 == 0) gap_odds = ($urandom_range(0, 2) == 0) ? 0 : 4;
            // drift the pool so that tag bits keep moving
            if ($urandom_range(0, 19) == 0)
                tag_pool[$urandom_range(0, 15)][$urandom_range(0, POOL_TAGS - 1)] =
                    10'($urandom);
            if ($urandom_range(0, 6) == 0) begin
                addr = 19'($urandom);
            end else begin
                set  = $urandom_range(0, 15);
                tag  = tag_pool[set][$urandom_range(0, POOL_TAGS - 1)];
                addr = line_addr(tag, 4'(set), 5'($urandom));
            end
            gap = 0;
            if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                gap = $urandom_range(1, 16);
            offer_access(addr, 1'($urandom), 1'($urandom), gap);
        end
        @(negedge i_clk);
        req_if.valid <= 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
